// File: rtl/assert_macros.svh
// assertion helpers, included by button_code_lock.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/bcl_pkg.sv
package bcl_pkg;

	// code and entry sizes
	localparam int NUM_DIGITS   = 4;
	localparam int DIGIT_W      = 2;
	localparam int CNT_W        = 3;
	localparam int HOLD_TICKS_W = 16;

	// configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// default sizes for the top level
	localparam int HOLD_COUNTER_WIDTH_DEF = 17;
	localparam int QUEUE_DEPTH_DEF        = 2;

	// register values after reset
	localparam logic [HOLD_TICKS_W-1:0] HOLD_TICKS_RST = 16'd2000;
	localparam logic [NUM_DIGITS-1:0][DIGIT_W-1:0] CODE_RST = {2'd3, 2'd3, 2'd2, 2'd1};

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_TICKS = 3'd0,
		REG_CODE_0     = 3'd1,
		REG_CODE_1     = 3'd2,
		REG_CODE_2     = 3'd3,
		REG_CODE_3     = 3'd4
	} reg_idx_t;

	// classified sample: which button wins, or none held
	typedef enum logic [DIGIT_W-1:0] {
		BTN_NONE  = 2'd0,
		BTN_ONE   = 2'd1,
		BTN_TWO   = 2'd2,
		BTN_THREE = 2'd3
	} btn_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [HOLD_TICKS_W-1:0]              hold_ticks;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   code_digit;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic             lamp_on;
		logic [CNT_W-1:0] digits_entered;
		logic             digit_taken;
		logic             code_checked;
		logic             code_matched;
	} res_t;

endpackage

// File: rtl/bcl_fifo.sv
module bcl_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             wr;
	logic             rd;

	// handshake qualification
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push & ~full;
	assign rd    = pop & ~empty;
	assign dout  = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

// File: rtl/bcl_front.sv
module bcl_front import bcl_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic button_one,
	input  logic button_two,
	input  logic button_three,
	output logic full,
	input  logic btn_pop,
	output btn_t btn,
	output logic btn_empty
);

	btn_t btn_class;
	logic [DIGIT_W-1:0] btn_raw;

	// priority pick: button 1 over 2 over 3
	always_comb begin
		if (button_one) begin
			btn_class = BTN_ONE;
		end else if (button_two) begin
			btn_class = BTN_TWO;
		end else if (button_three) begin
			btn_class = BTN_THREE;
		end else begin
			btn_class = BTN_NONE;
		end
	end

	// queue of classified samples toward the back end
	bcl_fifo #(
		.WIDTH (DIGIT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (btn_class),
		.full   (full),
		.pop    (btn_pop),
		.dout   (btn_raw),
		.empty  (btn_empty)
	);

	assign btn = btn_t'(btn_raw);

endmodule

// File: rtl/bcl_back.sv
module bcl_back import bcl_pkg::*; #(
	parameter int HOLD_COUNTER_WIDTH = HOLD_COUNTER_WIDTH_DEF,
	parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  btn_t btn,
	input  logic btn_empty,
	output logic btn_pop,
	input  logic res_pop,
	output res_t res,
	output logic res_empty
);

	localparam int CMP_W = (HOLD_COUNTER_WIDTH > HOLD_TICKS_W) ?
		HOLD_COUNTER_WIDTH : HOLD_TICKS_W;

	logic                               lamp_q;
	logic                               press_q;
	logic                               latched_q;
	logic [HOLD_COUNTER_WIDTH-1:0]      elapsed_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] entered_q;
	logic [CNT_W-1:0]                   cnt_q;

	logic                               lamp_nx;
	logic                               press_nx;
	logic                               latched_nx;
	logic [HOLD_COUNTER_WIDTH-1:0]      elapsed_nx;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] entered_nx;
	logic [CNT_W-1:0]                   cnt_nx;
	logic                               hold_done;
	logic                               step;
	logic                               res_full;
	res_t                               res_nx;

	// take an item when there is room for its result
	assign step    = ~btn_empty & ~res_full;
	assign btn_pop = step;

	// per-sample state update
	always_comb begin
		lamp_nx    = lamp_q;
		press_nx   = press_q;
		latched_nx = latched_q;
		entered_nx = entered_q;
		cnt_nx     = cnt_q;
		res_nx     = '0;

		// hold timer restarts between presses, saturates while held
		if (!press_q) begin
			elapsed_nx = '0;
		end else if (&elapsed_q) begin
			elapsed_nx = elapsed_q;
		end else begin
			elapsed_nx = elapsed_q + 1'b1;
		end
		hold_done = CMP_W'(elapsed_nx) > CMP_W'(cfg.hold_ticks);

		if (btn == BTN_NONE) begin
			press_nx   = 1'b0;
			latched_nx = 1'b0;
		end else if (cnt_q >= CNT_W'(NUM_DIGITS)) begin
			// full entry: compare and clear
			res_nx.code_checked = 1'b1;
			if (entered_q == cfg.code_digit) begin
				res_nx.code_matched = 1'b1;
				lamp_nx             = ~lamp_q;
			end
			entered_nx = '0;
			cnt_nx     = '0;
		end else begin
			press_nx = 1'b1;
			if (hold_done && !latched_q) begin
				entered_nx[cnt_q[DIGIT_W-1:0]] = btn;
				latched_nx         = 1'b1;
				cnt_nx             = cnt_q + 1'b1;
				res_nx.digit_taken = 1'b1;
			end
		end

		res_nx.lamp_on        = lamp_nx;
		res_nx.digits_entered = cnt_nx;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q    <= 1'b0;
			press_q   <= 1'b0;
			latched_q <= 1'b0;
			elapsed_q <= '0;
			entered_q <= '0;
			cnt_q     <= '0;
		end else if (step) begin
			lamp_q    <= lamp_nx;
			press_q   <= press_nx;
			latched_q <= latched_nx;
			elapsed_q <= elapsed_nx;
			entered_q <= entered_nx;
			cnt_q     <= cnt_nx;
		end
	end

	// result queue toward the consumer
	bcl_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.din    (res_nx),
		.full   (res_full),
		.pop    (res_pop),
		.dout   (res),
		.empty  (res_empty)
	);

endmodule

// File: rtl/button_code_lock.sv
// Button code lock: push one sample of the three button levels per clock (one
// sample stands for one millisecond) and pop one result item per sample. The
// front end classifies each sample to the winning button and queues it; the
// back end updates the hold timer, the entered code and the lamp for each
// item, so the block sustains one item per clock while no queue stalls, and
// each result goes through the sample queue and the result queue. Stalls on
// either side are absorbed by the two small queues. Registers are written by
// the user through wr_en / wr_index / wr_data only while no item is in flight
// (the block has no guard): index 0 is the hold time in ticks, indexes 1 to 4
// the four code digits; other indexes are ignored. No clearing pass follows reset.
`include "assert_macros.svh"

module button_code_lock import bcl_pkg::*; #(
	parameter int HOLD_COUNTER_WIDTH = HOLD_COUNTER_WIDTH_DEF,
	parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  push,
	output logic                  full,
	input  logic                  button_one,
	input  logic                  button_two,
	input  logic                  button_three,
	output logic                  empty,
	input  logic                  pop,
	output logic                  lamp_on,
	output logic [CNT_W-1:0]      digits_entered,
	output logic                  digit_taken,
	output logic                  code_checked,
	output logic                  code_matched
);

	cfg_t cfg_q;
	btn_t btn;
	logic btn_empty;
	logic btn_pop;
	res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks <= HOLD_TICKS_RST;
			cfg_q.code_digit <= CODE_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_HOLD_TICKS: cfg_q.hold_ticks <= wr_data[HOLD_TICKS_W-1:0];
				REG_CODE_0:     cfg_q.code_digit[0] <= wr_data[DIGIT_W-1:0];
				REG_CODE_1:     cfg_q.code_digit[1] <= wr_data[DIGIT_W-1:0];
				REG_CODE_2:     cfg_q.code_digit[2] <= wr_data[DIGIT_W-1:0];
				REG_CODE_3:     cfg_q.code_digit[3] <= wr_data[DIGIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sample classification and queue
	bcl_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.button_one   (button_one),
		.button_two   (button_two),
		.button_three (button_three),
		.full         (full),
		.btn_pop      (btn_pop),
		.btn          (btn),
		.btn_empty    (btn_empty)
	);

	// code entry and lamp control
	bcl_back #(
		.HOLD_COUNTER_WIDTH (HOLD_COUNTER_WIDTH),
		.QUEUE_DEPTH        (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.btn       (btn),
		.btn_empty (btn_empty),
		.btn_pop   (btn_pop),
		.res_pop   (pop),
		.res       (res),
		.res_empty (empty)
	);

	// result fields
	assign lamp_on        = res.lamp_on;
	assign digits_entered = res.digits_entered;
	assign digit_taken    = res.digit_taken;
	assign code_checked   = res.code_checked;
	assign code_matched   = res.code_matched;

	// sanity checks on the result item
	`ASSERT_NEVER(a_cnt_range, !empty && (digits_entered > CNT_W'(NUM_DIGITS)), "entry count above four")
	`ASSERT_ALWAYS(a_match_checked, !empty && code_matched |-> code_checked, "match without check")
	`ASSERT_NEVER(a_take_and_check, !empty && digit_taken && code_checked, "digit taken on check sample")
	`ASSERT_ALWAYS(a_take_counts, !empty && digit_taken |-> (digits_entered != '0), "digit taken, count zero")

endmodule

// File: tb/sv/button_code_lock_tb.sv
`timescale 1ns / 100ps

module button_code_lock_tb;
	import bcl_pkg::*;

	// indexes past the last register, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 560;
	localparam int PHASE_ITEMS  = 150;
	localparam int SHORT_PRESS  = 120;

	// one sample of the three button levels
	typedef struct packed {
		logic one;
		logic two;
		logic three;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic push = 1'b0;
	logic full;
	logic button_one = 1'b0;
	logic button_two = 1'b0;
	logic button_three = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic lamp_on;
	logic [CNT_W-1:0] digits_entered;
	logic digit_taken;
	logic code_checked;
	logic code_matched;

	// samples waiting to be pushed and responses waiting to be popped
	sample_t sample_queue[$];
	res_t due_responses[$];
	int samples_queued = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	// lock state as the testbench tracks it
	logic [HOLD_TICKS_W-1:0] cfg_hold_ticks;
	btn_t cfg_code [NUM_DIGITS];
	logic lamp_level;
	logic press_active;
	logic digit_latched;
	logic [HOLD_COUNTER_WIDTH_DEF-1:0] hold_elapsed;
	btn_t entered_code [NUM_DIGITS];
	logic [CNT_W-1:0] entry_count;

	button_code_lock i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.push(push),
		.full(full),
		.button_one(button_one),
		.button_two(button_two),
		.button_three(button_three),
		.empty(empty),
		.pop(pop),
		.lamp_on(lamp_on),
		.digits_entered(digits_entered),
		.digit_taken(digit_taken),
		.code_checked(code_checked),
		.code_matched(code_matched)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// lock response to one sample, advances the tracked state
	function automatic res_t predict_lock_response(sample_t s);
		res_t r;
		btn_t winner;
		r = '0;
		if (!press_active)
			hold_elapsed = '0;
		else if (hold_elapsed != '1)
			hold_elapsed = hold_elapsed + 1'b1;

		if (!s.one && !s.two && !s.three) begin
			press_active = 1'b0;
			digit_latched = 1'b0;
		end else if (entry_count >= NUM_DIGITS) begin
			// compare sample: press and latch stay as they are
			r.code_checked = 1'b1;
			if (entered_code == cfg_code) begin
				r.code_matched = 1'b1;
				lamp_level = ~lamp_level;
			end
			foreach (entered_code[i])
				entered_code[i] = BTN_NONE;
			entry_count = '0;
		end else begin
			winner = s.one ? BTN_ONE : (s.two ? BTN_TWO : BTN_THREE);
			press_active = 1'b1;
			if (hold_elapsed > cfg_hold_ticks && !digit_latched) begin
				entered_code[entry_count[DIGIT_W-1:0]] = winner;
				digit_latched = 1'b1;
				entry_count = entry_count + 1'b1;
				r.digit_taken = 1'b1;
			end
		end
		r.lamp_on = lamp_level;
		r.digits_entered = entry_count;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// sample with the given button winning, lower-priority buttons random
	function automatic sample_t mask_for(btn_t d);
		sample_t s;
		s = sample_t'($urandom_range(0, 7));
		case (d)
			BTN_ONE: s.one = 1'b1;
			BTN_TWO: begin
				s.one = 1'b0;
				s.two = 1'b1;
			end
			BTN_THREE: s = '{one: 1'b0, two: 1'b0, three: 1'b1};
			default: s = '0;
		endcase
		return s;
	endfunction

	task automatic add_sample(sample_t s);
		sample_queue.push_back(s);
		samples_queued++;
	endtask

	task automatic add_press(btn_t d, int len);
		repeat (len) add_sample(mask_for(d));
	endtask

	task automatic add_release(int len);
		repeat (len) add_sample('0);
	endtask

	// hold length around the point where a digit registers
	function automatic int press_len();
		if ($urandom_range(0, 7) == 0)
			return int'(cfg_hold_ticks) + 1;
		return int'(cfg_hold_ticks) + $urandom_range(2, 4);
	endfunction

	// four presses and a compare press, aimed at the code half the time
	task automatic add_code_entry();
		bit aim;
		btn_t d;
		aim = $urandom_range(0, 1);
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (aim && cfg_code[k] != BTN_NONE)
				d = cfg_code[k];
			else
				d = btn_t'($urandom_range(1, 3));
			add_press(d, press_len());
			add_release($urandom_range(1, 3));
		end
		add_press(btn_t'($urandom_range(1, 3)), $urandom_range(1, 3));
		add_release($urandom_range(1, 2));
	endtask

	// register write, tracked config follows at the edge that takes it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_HOLD_TICKS: cfg_hold_ticks = data;
			REG_CODE_0, REG_CODE_1, REG_CODE_2, REG_CODE_3:
				cfg_code[2'(idx - REG_CODE_0)] = btn_t'(data[DIGIT_W-1:0]);
			default: ;
		endcase
	endtask

	// all items pushed and all responses popped
	task automatic wait_idle();
		while (sample_queue.size() != 0 || push || due_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: bursts of items with random gaps
	always @(posedge clk) begin : driver
		sample_t nxt;
		static int burst_left = 0;
		static int gap_left = 0;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				due_responses.push_back(predict_lock_response({button_one, button_two,
					button_three}));
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					nxt = sample_queue.pop_front();
					button_one <= nxt.one;
					button_two <= nxt.two;
					button_three <= nxt.three;
					push <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver: pop follows a random 16-bit pattern, renewed each time the 6-bit phase counter wraps
	always @(posedge clk) begin : receiver
		static logic [15:0] stall_bits = '1;
		static logic [5:0] stall_phase = '0;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				if ($urandom_range(0, 3) == 0)
					stall_bits = '1;
				else
					stall_bits = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
			end
			pop <= stall_bits[stall_phase[3:0]];
			stall_phase = stall_phase + 1'b1;
		end
	end

	// monitor: compare each popped item with the oldest prediction
	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n && pop && !empty) begin
			if (due_responses.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %b", $time,
					{lamp_on, digits_entered, digit_taken, code_checked, code_matched});
				mismatches++;
			end else begin
				want = due_responses.pop_front();
				check_field("lamp_on", want.lamp_on, lamp_on);
				check_field("digits_entered", want.digits_entered, digits_entered);
				check_field("digit_taken", want.digit_taken, digit_taken);
				check_field("code_checked", want.code_checked, code_checked);
				check_field("code_matched", want.code_matched, code_matched);
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int rand_start;
		int phase_start;
		cfg_hold_ticks = HOLD_TICKS_RST;
		foreach (cfg_code[i])
			cfg_code[i] = btn_t'(CODE_RST[i]);
		lamp_level = 1'b0;
		press_active = 1'b0;
		digit_latched = 1'b0;
		hold_elapsed = '0;
		foreach (entered_code[i])
			entered_code[i] = BTN_NONE;
		entry_count = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hold time after reset: a press well short of it takes no digit
		add_press(BTN_ONE, SHORT_PRESS);
		add_release(1);
		wait_idle();

		// zero hold time, code 1 2 3 1, upper data bits and unused indexes
		write_reg(REG_HOLD_TICKS, '0);
		write_reg(REG_CODE_0, 16'h0001);
		write_reg(REG_CODE_1, 16'hABCE);
		write_reg(REG_CODE_2, 16'h0003);
		write_reg(REG_CODE_3, 16'hFFF1);
		for (int i = REG_UNUSED_FIRST; i < 2 ** CFG_IDX_W; i++)
			write_reg(i[CFG_IDX_W-1:0], '1);
		wr_en <= 1'b0;

		// one-sample press, all button mixes, latch on a long hold,
		// matching compare while the button stays down
		add_sample(3'b111);
		add_sample(3'b000);
		add_sample(3'b100);
		add_sample(3'b110);
		add_sample(3'b000);
		add_sample(3'b011);
		add_sample(3'b011);
		add_sample(3'b000);
		add_sample(3'b001);
		add_sample(3'b001);
		add_sample(3'b001);
		add_sample(3'b000);
		add_sample(3'b101);
		add_sample(3'b101);
		add_sample(3'b000);
		add_sample(3'b010);
		add_sample(3'b010);
		add_sample(3'b000);
		wait_idle();

		// longest hold time: a short press takes no digit
		write_reg(REG_HOLD_TICKS, '1);
		wr_en <= 1'b0;
		add_press(BTN_TWO, SHORT_PRESS / 5);
		add_release(2);
		wait_idle();

		// random phases of short hold times and random codes
		rand_start = samples_queued;
		while (samples_queued - rand_start < RANDOM_ITEMS) begin
			wait_idle();
			write_reg(REG_HOLD_TICKS, 16'($urandom_range(0, 5)));
			for (int k = 0; k < NUM_DIGITS; k++)
				write_reg(CFG_IDX_W'(REG_CODE_0 + k), {14'($urandom),
					($urandom_range(0, 11) == 0) ? BTN_NONE : btn_t'($urandom_range(1, 3))});
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, 2 ** CFG_IDX_W - 1)),
					16'($urandom));
			wr_en <= 1'b0;
			phase_start = samples_queued;
			while (samples_queued - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) != 0)
					add_code_entry();
				else
					repeat ($urandom_range(1, 8)) add_sample(sample_t'($urandom_range(0, 7)));
			end
		end

		wait_idle();
		if (mismatches == 0 && due_responses.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
